>>> src/cdte_pkg.sv
// Shared constants, types and the month table for the civil date to epoch converter.
`default_nettype none
package cdte_pkg;

	localparam int YearW  = 12;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;
	localparam int EpochW = 32;
	localparam int DaysW  = 21;
	localparam int TodW   = 17;

	localparam logic [YearW-1:0]  EpochYear    = 12'd1970;
	localparam logic [12:0]       Recip100     = 13'd5243;
	localparam int                RecipShift   = 19;
	localparam logic [DaysW-1:0]  LeapsToEpoch = 21'd477;
	localparam logic [8:0]        DaysPerYear  = 9'd365;
	localparam logic [16:0]       SecsPerDay   = 17'd86400;
	localparam logic [11:0]       SecsPerHour  = 12'd3600;
	localparam logic [5:0]        SecsPerMin   = 6'd60;
	localparam logic [6:0]        Hundred      = 7'd100;
	localparam logic [MonthW-1:0] MonthFeb     = 4'd2;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	function automatic logic [8:0] month_offset(input logic [MonthW-1:0] month);
		logic [8:0] off;
		case (month)
			4'd0, 4'd1: off = 9'd0;
			4'd2:       off = 9'd31;
			4'd3:       off = 9'd59;
			4'd4:       off = 9'd90;
			4'd5:       off = 9'd120;
			4'd6:       off = 9'd151;
			4'd7:       off = 9'd181;
			4'd8:       off = 9'd212;
			4'd9:       off = 9'd243;
			4'd10:      off = 9'd273;
			4'd11:      off = 9'd304;
			default:    off = 9'd334;
		endcase
		return off;
	endfunction

endpackage
`default_nettype wire

>>> src/cdte_days.sv
// Day count stages: leap counting by reciprocal division, month table and time of day.
`default_nettype none
module cdte_days import cdte_pkg::*; (
	input  wire logic              clk,
	input  wire stage_en_t         en,
	input  wire logic [YearW-1:0]  year_value,
	input  wire logic [MonthW-1:0] month_value,
	input  wire logic [DayW-1:0]   day_value,
	input  wire logic [HourW-1:0]  hour_value,
	input  wire logic [MinW-1:0]   minute_value,
	input  wire logic [SecW-1:0]   second_value,
	output logic [DaysW-1:0]       days_s2,
	output logic [TodW-1:0]        tod_s2
);

	logic [YearW-1:0]  ym1;
	logic [24:0]       prod_y;
	logic [24:0]       prod_ym1;
	logic [22:0]       prod_q;

	logic [YearW-1:0]  year_s1;
	logic [YearW-1:0]  ym1_s1;
	logic [5:0]        q100_y_s1;
	logic [5:0]        q100_ym1_s1;
	logic [3:0]        q400_ym1_s1;
	logic              after_s1;
	logic [MonthW-1:0] month_s1;
	logic [DayW-1:0]   day_s1;
	logic [TodW-1:0]   tod_s1;

	logic              leap;
	logic [12:0]       hund;
	logic [DaysW-1:0]  leaps;
	logic [DaysW-1:0]  whole;
	logic [DaysW-1:0]  days;

	always_comb begin
		ym1      = year_value - 12'd1;
		prod_y   = 25'(year_value) * 25'(Recip100);
		prod_ym1 = 25'(ym1) * 25'(Recip100);
		prod_q   = 23'(ym1[YearW-1:2]) * 23'(Recip100);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1     <= year_value;
			ym1_s1      <= ym1;
			q100_y_s1   <= prod_y[RecipShift +: 6];
			q100_ym1_s1 <= prod_ym1[RecipShift +: 6];
			q400_ym1_s1 <= prod_q[RecipShift +: 4];
			after_s1    <= year_value > EpochYear;
			month_s1    <= month_value;
			day_s1      <= day_value;
			tod_s1      <= TodW'(hour_value) * TodW'(SecsPerHour)
			             + TodW'(minute_value) * TodW'(SecsPerMin)
			             + TodW'(second_value);
		end
	end

	always_comb begin
		hund  = 13'(q100_y_s1) * 13'(Hundred);
		leap  = (year_s1[1:0] == 2'd0)
		     && (({1'b0, year_s1} != hund) || (q100_y_s1[1:0] == 2'd0));
		leaps = DaysW'(ym1_s1[YearW-1:2]) - DaysW'(q100_ym1_s1) + DaysW'(q400_ym1_s1);
		whole = '0;
		if (after_s1) begin
			whole = DaysW'(year_s1 - EpochYear) * DaysW'(DaysPerYear) + leaps - LeapsToEpoch;
		end
		days = whole + DaysW'(month_offset(month_s1)) + DaysW'(day_s1)
		     + DaysW'(leap && (month_s1 > MonthFeb));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			days_s2 <= days;
			tod_s2  <= tod_s1;
		end
	end

endmodule
`default_nettype wire

>>> src/cdte_secs.sv
// Seconds stages: scale the day count, take off one day and add the time of day modulo 2^32.
`default_nettype none
module cdte_secs import cdte_pkg::*; (
	input  wire logic             clk,
	input  wire stage_en_t        en,
	input  wire logic [DaysW-1:0] days_s2,
	input  wire logic [TodW-1:0]  tod_s2,
	output logic [EpochW-1:0]     secs_s4
);

	logic [37:0]       prod;
	logic [EpochW-1:0] dsec_s3;
	logic [TodW-1:0]   tod_s3;

	assign prod = 38'(days_s2) * 38'(SecsPerDay);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dsec_s3 <= prod[EpochW-1:0];
			tod_s3  <= tod_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			secs_s4 <= dsec_s3 - EpochW'(SecsPerDay) + EpochW'(tod_s3);
		end
	end

endmodule
`default_nettype wire

>>> src/civil_date_to_epoch_seconds.sv
// Top level of the civil date to epoch seconds converter.
// Pipeline: four register stages, s1 to s4.
// Throughput: one transaction per cycle while out_stall is low; set by the four-stage pipeline.
// A stall holds each occupied stage with no empty stage ahead of it; stages behind a gap still advance.
// Reset clears the stage valid bits only.
`default_nettype none
module civil_date_to_epoch_seconds import cdte_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [YearW-1:0]  year_value,
	input  wire logic [MonthW-1:0] month_value,
	input  wire logic [DayW-1:0]   day_value,
	input  wire logic [HourW-1:0]  hour_value,
	input  wire logic [MinW-1:0]   minute_value,
	input  wire logic [SecW-1:0]   second_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [EpochW-1:0]      epoch_seconds
);

	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             valid_s4;
	stage_en_t        en;
	logic [DaysW-1:0] days_s2;
	logic [TodW-1:0]  tod_s2;

	always_comb begin
		en.s4 = !valid_s4 || !out_stall;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	cdte_days u_days (
		.clk          (clk),
		.en           (en),
		.year_value   (year_value),
		.month_value  (month_value),
		.day_value    (day_value),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value),
		.days_s2      (days_s2),
		.tod_s2       (tod_s2)
	);

	cdte_secs u_secs (
		.clk     (clk),
		.en      (en),
		.days_s2 (days_s2),
		.tod_s2  (tod_s2),
		.secs_s4 (epoch_seconds)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the civil date to epoch seconds converter.
module testbench;
	import cdte_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int TailCycles   = 12;
	localparam int PhaseItems   = 450;
	localparam int HoldOffCycles = 120;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
		logic [HourW-1:0]  hour;
		logic [MinW-1:0]   minute;
		logic [SecW-1:0]   sec;
	} civil_date_t;

	class epoch_scoreboard;
		logic [EpochW-1:0] expected_epochs[$];
		int checked;
		int failures;

		function bit is_leap(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int unsigned leaps_through(int unsigned y);
			return y / 4 - y / 100 + y / 400;
		endfunction

		function int unsigned month_length(int unsigned m);
			if (m == MonthFeb)
				return 28;
			if (m == 4 || m == 6 || m == 9 || m == 11)
				return 30;
			return 31;
		endfunction

		function int unsigned month_start_day(logic [MonthW-1:0] m);
			int unsigned total;
			int unsigned last;
			total = 0;
			last = (m == 0) ? 1 : (m > 12) ? 12 : m;
			for (int unsigned k = 1; k < last; k++)
				total += month_length(k);
			return total;
		endfunction

		function logic [EpochW-1:0] predict_epoch(civil_date_t d);
			int unsigned y;
			int unsigned days;
			y = d.year;
			days = 0;
			if (y > EpochYear)
				days = 365 * (y - EpochYear) + leaps_through(y - 1)
					- leaps_through(EpochYear - 1);
			days += month_start_day(d.month);
			if (d.month > MonthFeb && is_leap(y))
				days++;
			days = days + d.day - 1;
			return days * 86400 + d.hour * 3600 + d.minute * 60 + d.sec;
		endfunction

		function void note_date(civil_date_t d);
			expected_epochs.push_back(predict_epoch(d));
		endfunction

		function void check_epoch(logic [EpochW-1:0] got);
			logic [EpochW-1:0] want;
			if (expected_epochs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected epoch_seconds %0d with nothing pending", got);
				return;
			end
			want = expected_epochs.pop_front();
			checked++;
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("epoch_seconds mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int pending();
			return expected_epochs.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [YearW-1:0]  year_value = '0;
	logic [MonthW-1:0] month_value = '0;
	logic [DayW-1:0]   day_value = '0;
	logic [HourW-1:0]  hour_value = '0;
	logic [MinW-1:0]   minute_value = '0;
	logic [SecW-1:0]   second_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [EpochW-1:0] epoch_seconds;

	epoch_scoreboard sb = new;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int cycles = 0;

	civil_date_to_epoch_seconds dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.year_value   (year_value),
		.month_value  (month_value),
		.day_value    (day_value),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.epoch_seconds(epoch_seconds)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_epoch(epoch_seconds);
	end

	function automatic civil_date_t make_date(int y, int m, int d, int h, int mi, int s);
		civil_date_t c;
		c.year = YearW'(y);
		c.month = MonthW'(m);
		c.day = DayW'(d);
		c.hour = HourW'(h);
		c.minute = MinW'(mi);
		c.sec = SecW'(s);
		return c;
	endfunction

	function automatic civil_date_t random_date();
		civil_date_t d;
		int unsigned len;
		if ($urandom_range(99) < 85) begin
			d.year = YearW'($urandom_range(2105, 1970));
			d.month = MonthW'($urandom_range(12, 1));
			len = sb.month_length(d.month);
			if (d.month == MonthFeb && sb.is_leap(d.year))
				len++;
			d.day = DayW'($urandom_range(len, 1));
			d.hour = HourW'($urandom_range(23, 0));
			d.minute = MinW'($urandom_range(59, 0));
			d.sec = SecW'($urandom_range(59, 0));
		end else begin
			d.year = YearW'($urandom);
			d.month = MonthW'($urandom);
			d.day = DayW'($urandom);
			d.hour = HourW'($urandom);
			d.minute = MinW'($urandom);
			d.sec = SecW'($urandom);
		end
		return d;
	endfunction

	task automatic send_date(civil_date_t d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		year_value <= d.year;
		month_value <= d.month;
		day_value <= d.day;
		hour_value <= d.hour;
		minute_value <= d.minute;
		second_value <= d.sec;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_date(d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic send_edge_dates();
		send_date(make_date(1970, 1, 1, 0, 0, 0));
		send_date(make_date(0, 0, 0, 0, 0, 0));
		send_date(make_date(4095, 15, 31, 31, 63, 63));
		send_date(make_date(1969, 6, 15, 12, 30, 30));
		send_date(make_date(1900, 3, 1, 0, 0, 0));
		send_date(make_date(1968, 3, 1, 0, 0, 0));
		send_date(make_date(1972, 2, 29, 23, 59, 59));
		send_date(make_date(1972, 3, 1, 0, 0, 0));
		send_date(make_date(2000, 2, 29, 23, 59, 59));
		send_date(make_date(2000, 3, 1, 0, 0, 0));
		send_date(make_date(2100, 3, 1, 0, 0, 0));
		send_date(make_date(2104, 12, 31, 23, 59, 59));
		send_date(make_date(2105, 12, 31, 23, 59, 59));
		send_date(make_date(2106, 2, 7, 6, 28, 15));
		send_date(make_date(2106, 2, 7, 6, 28, 16));
		send_date(make_date(2038, 1, 19, 3, 14, 7));
		send_date(make_date(1970, 0, 10, 5, 6, 7));
		send_date(make_date(2024, 13, 1, 0, 0, 0));
		send_date(make_date(2023, 14, 5, 1, 2, 3));
		send_date(make_date(2024, 15, 31, 23, 59, 59));
		send_date(make_date(2024, 1, 0, 0, 0, 0));
		send_date(make_date(1970, 1, 0, 0, 0, 0));
		send_date(make_date(1999, 12, 31, 31, 63, 63));
		send_date(make_date(2048, 10, 16, 16, 32, 32));
	endtask

	task automatic run_phase(int idle, int stall, bit long_hold);
		idle_pct = idle;
		stall_pct = stall;
		if (long_hold)
			hold_req = HoldOffCycles;
		for (int i = 0; i < PhaseItems; i++)
			send_date(random_date());
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_edge_dates();
		drain();
		run_phase(0, 0, 1'b1);
		run_phase(86, 0, 1'b0);
		run_phase(0, 86, 1'b0);
		run_phase(8, 8, 1'b0);
		repeat (TailCycles) @(posedge clk);
		$display("Checked %0d conversions: calendar edges, wrap-around, odd field values,",
			sb.checked);
		$display("then random dates with free, sender-idle, receiver-stall, mixed and held-off flow.");
		if (sb.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> filelist.f
src/cdte_pkg.sv
src/cdte_days.sv
src/cdte_secs.sv
src/civil_date_to_epoch_seconds.sv
tb/testbench.sv
